// ===== rtl/rf_power_vswr_monitor_core_defines.svh =====
// Assertion macros for the checker file of the power monitor.
`ifndef RF_POWER_VSWR_MONITOR_CORE_DEFINES_SVH
`define RF_POWER_VSWR_MONITOR_CORE_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define RPVM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rpvm check failed");

// Property checked on every rising edge, reset included.
`define RPVM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rpvm check failed");

`endif

// ===== rtl/rpvm_pkg.sv =====
package rpvm_pkg;

   // Depth of the forward power window.
   localparam int WINDOW_DEPTH = 32;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int SCAN_W       = $clog2(WINDOW_DEPTH + 1);

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // 0.1074^2 * 0.02 in Q0.24 and 0.2441 in Q0.16, both rounded to nearest.
   localparam logic [11:0] POWER_K = 12'd3870;
   localparam logic [13:0] SCALE_K = 14'd15997;

   // The VSWR numerator 10*(f+r) is at most 20460, so 15 quotient bits.
   localparam int DIV_W     = 15;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_VSWR_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_LIMIT = 8'd1;
   localparam logic [7:0] VSWR_LIMIT_RESET = 8'd30;
   localparam logic [7:0] TEMP_LIMIT_RESET = 8'd60;

   typedef struct packed {
      logic [9:0] fwd_sample;
      logic [9:0] rev_sample;
      logic [9:0] current_sample;
      logic [9:0] heat_sample;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] fwd_watts;
      logic [7:0] rev_watts;
      logic [7:0] pa_amps_tenths;
      logic [7:0] heatsink_celsius;
      logic [7:0] vswr_tenths;
      logic [7:0] peak_fwd_watts;
      logic       vswr_high;
      logic       temp_high;
   } rsp_payload_type;

   // One classified item travelling from the front to the back.
   typedef struct packed {
      logic [7:0] fwd_watts;
      logic [7:0] rev_watts;
      logic [7:0] pa_amps_tenths;
      logic [7:0] heatsink_celsius;
      logic [9:0] fwd_raw;
      logic [9:0] rev_raw;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_port_type;

   typedef struct packed {
      logic [7:0] vswr_limit;
      logic [7:0] temp_limit;
   } cfg_type;

endpackage

// ===== rtl/rpvm_front.sv =====
module rpvm_front
   import rpvm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output q_port_type      push,
   input  logic            q_full
);

   localparam logic [1:0] F_IDLE  = 2'd0;
   localparam logic [1:0] F_SQR   = 2'd1;
   localparam logic [1:0] F_SCALE = 2'd2;
   localparam logic [1:0] F_PUSH  = 2'd3;

   logic [1:0]      state_ff, state_in;
   req_payload_type samp_ff;
   logic [19:0]     fsq_ff, rsq_ff;
   logic [23:0]     amp_prod_ff, heat_prod_ff;
   logic [31:0]     fpow_ff, rpow_ff;

   assign req_ready = (state_ff == F_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req_valid) state_in = F_SQR;
         F_SQR:   state_in = F_SCALE;
         F_SCALE: state_in = F_PUSH;
         F_PUSH:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Squares and linear products first, then the power constant.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         samp_ff <= req_payload;
      end
      if (state_ff == F_SQR) begin
         fsq_ff       <= 20'(samp_ff.fwd_sample) * 20'(samp_ff.fwd_sample);
         rsq_ff       <= 20'(samp_ff.rev_sample) * 20'(samp_ff.rev_sample);
         amp_prod_ff  <= 24'(samp_ff.current_sample) * 24'(SCALE_K);
         heat_prod_ff <= 24'(samp_ff.heat_sample) * 24'(SCALE_K);
      end
      if (state_ff == F_SCALE) begin
         fpow_ff <= 32'(fsq_ff) * 32'(POWER_K);
         rpow_ff <= 32'(rsq_ff) * 32'(POWER_K);
      end
   end

   // The input widths keep every scaled value below 256, so the integer
   // part is taken as it stands.
   always_comb begin
      push.valid                  = (state_ff == F_PUSH);
      push.entry.fwd_watts        = fpow_ff[31:24];
      push.entry.rev_watts        = rpow_ff[31:24];
      push.entry.pa_amps_tenths   = amp_prod_ff[23:16];
      push.entry.heatsink_celsius = heat_prod_ff[23:16];
      push.entry.fwd_raw          = samp_ff.fwd_sample;
      push.entry.rev_raw          = samp_ff.rev_sample;
   end

endmodule

// ===== rtl/rpvm_queue.sv =====
module rpvm_queue
   import rpvm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_port_type push,
   output logic       q_full,
   output q_port_type pop,
   input  logic       pop_ack
);

   q_entry_type         entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0] count_ff;
   logic                do_push, do_pop;

   assign q_full    = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign do_push   = push.valid && !q_full;
   assign do_pop    = pop_ack && (count_ff != '0);
   assign pop.valid = (count_ff != '0);
   assign pop.entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/rpvm_back.sv =====
module rpvm_back
   import rpvm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  q_port_type      pop,
   output logic            pop_ack,
   input  cfg_type         cfg,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_RUN  = 2'd1;
   localparam logic [1:0] B_HOLD = 2'd2;

   logic [1:0]            state_ff, state_in;
   q_entry_type           item_ff;

   // Window memory with one valid bit per entry; an entry never written
   // since reset reads as zero.
   logic [7:0]            win_mem [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] win_vld_ff;
   logic [WIN_AW-1:0]     pos_ff;
   logic [WIN_AW-1:0]     rd_addr;
   logic [7:0]            rd_data_ff;
   logic                  rd_ok_ff;
   logic                  rd_vld_ff;
   logic [SCAN_W-1:0]     scan_cnt_ff;
   logic [7:0]            peak_ff;
   logic                  scan_busy;

   // Restoring divider for 10*(f+r)/(f-r), one quotient bit per cycle.
   logic [9:0]            rem_ff;
   logic [DIV_W-1:0]      quo_ff;
   logic [9:0]            den_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic                  ratio_ok_ff;
   logic [10:0]           trial;
   logic [10:0]           diff;
   logic                  div_busy;

   logic                  start;
   logic                  out_free;
   logic [10:0]           sum_raw;
   logic [7:0]            vswr;

   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   assign start     = (state_ff == B_IDLE) && pop.valid;
   assign pop_ack   = start;
   assign scan_busy = (scan_cnt_ff != SCAN_W'(WINDOW_DEPTH));
   assign div_busy  = (div_cnt_ff != DIV_CNT_W'(DIV_W));
   assign rd_addr   = scan_cnt_ff[WIN_AW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sum_raw   = 11'(pop.entry.fwd_raw) + 11'(pop.entry.rev_raw);
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign diff      = trial - {1'b0, den_ff};

   always_comb begin
      if (!ratio_ok_ff) begin
         vswr = 8'd0;
      end else if (quo_ff[DIV_W-1:8] != '0) begin
         vswr = 8'd255;
      end else begin
         vswr = quo_ff[7:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (pop.valid) state_in = B_RUN;
         B_RUN:  if (!scan_busy && !rd_vld_ff && !div_busy) state_in = B_HOLD;
         B_HOLD: if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         pos_ff      <= '0;
         win_vld_ff  <= '0;
         rd_vld_ff   <= 1'b0;
         scan_cnt_ff <= SCAN_W'(WINDOW_DEPTH);
         div_cnt_ff  <= DIV_CNT_W'(DIV_W);
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == B_RUN) && scan_busy;
         if (start) begin
            win_vld_ff[pos_ff] <= 1'b1;
            pos_ff <= (pos_ff == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
            scan_cnt_ff <= '0;
            div_cnt_ff  <= '0;
         end else if (state_ff == B_RUN) begin
            if (scan_busy) begin
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
            end
            if (div_busy) begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
         end
      end
   end

   // Window memory: written at the ring position, read by the scan.
   always_ff @(posedge clock) begin
      if (start) begin
         win_mem[pos_ff] <= pop.entry.fwd_watts;
      end
      rd_data_ff <= win_mem[rd_addr];
      rd_ok_ff   <= win_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff     <= pop.entry;
         peak_ff     <= '0;
         rem_ff      <= '0;
         quo_ff      <= DIV_W'({sum_raw, 3'b000}) + DIV_W'({sum_raw, 1'b0});
         den_ff      <= pop.entry.fwd_raw - pop.entry.rev_raw;
         ratio_ok_ff <= (pop.entry.fwd_raw > pop.entry.rev_raw);
      end else if (state_ff == B_RUN) begin
         if (rd_vld_ff && rd_ok_ff && (rd_data_ff > peak_ff)) begin
            peak_ff <= rd_data_ff;
         end
         if (div_busy) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= diff[9:0];
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[9:0];
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   // Output register: the next item may be under way while this one waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == B_HOLD) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == B_HOLD) && out_free) begin
         rsp_data_ff.fwd_watts        <= item_ff.fwd_watts;
         rsp_data_ff.rev_watts        <= item_ff.rev_watts;
         rsp_data_ff.pa_amps_tenths   <= item_ff.pa_amps_tenths;
         rsp_data_ff.heatsink_celsius <= item_ff.heatsink_celsius;
         rsp_data_ff.vswr_tenths      <= vswr;
         rsp_data_ff.peak_fwd_watts   <= peak_ff;
         rsp_data_ff.vswr_high        <= (vswr >= cfg.vswr_limit);
         rsp_data_ff.temp_high        <= (item_ff.heatsink_celsius >= cfg.temp_limit);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== rtl/rf_power_vswr_monitor_core.sv =====
// RF power amplifier monitor: forward and reverse power, PA current,
// heatsink temperature, VSWR times ten and the peak forward power over a
// window of the last WINDOW_DEPTH items, with VSWR-high and temp-high flags.
//
// Channels: req_ carries one set of four 10-bit ADC samples per item, rsp_
// returns one result item per input item, in order. csr_ writes the VSWR
// limit (index 0) and the temperature limit (index 1); other indexes are
// ignored. csr_ready is always high. Limits are sampled when a result is
// formed, so write them only while the block is idle.
//
// Flow: the front steps through accept, two multiply stages and a push for
// each item and takes no new item before the push. The back is bounded by
// the peak scan, which reads the window memory one entry per cycle over
// WINDOW_DEPTH entries, with the restoring divider running alongside.
// Reset (synchronous, active high) clears the window valid bits so every
// entry reads as zero, returns the ring position to zero and loads the
// limits 30 and 60. A stalled receiver holds the result in the output
// register; the back finishes the next item and waits behind it, and the
// two-entry queue then fills until req_ready stays low.
module rf_power_vswr_monitor_core
   import rpvm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   cfg_type    cfg_ff;
   q_port_type push;
   q_port_type pop;
   logic       q_full;
   logic       pop_ack;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vswr_limit <= VSWR_LIMIT_RESET;
         cfg_ff.temp_limit <= TEMP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_VSWR_LIMIT) begin
            cfg_ff.vswr_limit <= csr_wdata;
         end else if (csr_index == CSR_TEMP_LIMIT) begin
            cfg_ff.temp_limit <= csr_wdata;
         end
      end
   end

   // Front: accepts an item and scales the samples.
   rpvm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .q_full      (q_full)
   );

   // Short queue that decouples the front from the back.
   rpvm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_full  (q_full),
      .pop     (pop),
      .pop_ack (pop_ack)
   );

   // Back: VSWR divider, window update, peak scan and output register.
   rpvm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop         (pop),
      .pop_ack     (pop_ack),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/rpvm_checker.sv =====
`include "rf_power_vswr_monitor_core_defines.svh"

module rpvm_checker
   import rpvm_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // No result survives a reset.
   `RPVM_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid)

   // A result that is not taken stays offered, unchanged.
   `RPVM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `RPVM_ASSERT(a_rsp_stable, clock, reset,
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))

   // The window always holds the newest forward power.
   `RPVM_ASSERT(a_peak_covers_fwd, clock, reset,
      rsp_valid |-> (rsp_payload.peak_fwd_watts >= rsp_payload.fwd_watts))

   // A valid VSWR ratio is at least one, so the reading is zero or ten up.
   `RPVM_ASSERT(a_vswr_range, clock, reset,
      rsp_valid |-> ((rsp_payload.vswr_tenths == 8'd0) || (rsp_payload.vswr_tenths >= 8'd10)))

endmodule

bind rf_power_vswr_monitor_core rpvm_checker u_rpvm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== test/tb_rf_power_vswr_monitor_core.sv =====
`timescale 1ns / 1ps

module tb_rf_power_vswr_monitor_core;
   import rpvm_pkg::*;

   // Gains of the scaling stages: power in Q0.24, current and temperature in Q0.16.
   localparam longint unsigned WATT_GAIN_Q24 = 3870;
   localparam longint unsigned UNIT_GAIN_Q16 = 15997;

   // The receiver holds off this long once, so the queue and the output register fill up.
   localparam int LONG_HOLD_CYCLES = 400;
   // Random items come in runs; each run is either full scale or mostly low power.
   localparam int RUN_LENGTH = 40;

   // Indexes that map to no register. Writes to them must leave both limits alone.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 8'd255;

   typedef struct {
      req_payload_type sample;
      bit              typed;
      rsp_payload_type reading;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = '0;

   // Shadow copy of the block state, kept in step with every accepted item.
   logic [7:0]  fwd_history [WINDOW_DEPTH];
   int unsigned history_pos;
   logic [7:0]  vswr_trip;
   logic [7:0]  temp_trip;

   rsp_payload_type expected_readings [$];
   stim_row_type    directed_rows [$];

   int  error_count = 0;
   int  items_sent = 0;
   int  readings_checked = 0;
   int  csr_writes = 0;
   int  send_gap_pct = 0;
   int  rsp_stall_pct = 0;
   bit  hold_request = 1'b0;

   rf_power_vswr_monitor_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is bounded no matter what the block does.
   initial begin
      #(4_000_000);
      $display("tb: failure");
      $finish;
   end

   task automatic log_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [7:0] clamp_byte(input longint unsigned v);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] line_watts(input logic [9:0] adc);
      longint unsigned a;
      a = adc;
      return clamp_byte((a * a * WATT_GAIN_Q24) >> 24);
   endfunction

   function automatic logic [7:0] unit_scale(input logic [9:0] adc);
      longint unsigned a;
      a = adc;
      return clamp_byte((a * UNIT_GAIN_Q16) >> 16);
   endfunction

   // Works out the reading for one sample set and advances the shadow window.
   function automatic rsp_payload_type predict_reading(input req_payload_type s);
      rsp_payload_type rd;
      longint unsigned f;
      longint unsigned r;
      logic [7:0]      top;
      f = s.fwd_sample;
      r = s.rev_sample;
      rd.fwd_watts        = line_watts(s.fwd_sample);
      rd.rev_watts        = line_watts(s.rev_sample);
      rd.pa_amps_tenths   = unit_scale(s.current_sample);
      rd.heatsink_celsius = unit_scale(s.heat_sample);
      // The ratio is only meaningful while forward exceeds reverse.
      rd.vswr_tenths = (f > r) ? clamp_byte((10 * (f + r)) / (f - r)) : 8'd0;
      fwd_history[history_pos] = rd.fwd_watts;
      history_pos = (history_pos == WINDOW_DEPTH - 1) ? 0 : history_pos + 1;
      top = 8'd0;
      for (int i = 0; i < WINDOW_DEPTH; i++)
         if (fwd_history[i] > top) top = fwd_history[i];
      rd.peak_fwd_watts = top;
      rd.vswr_high = (rd.vswr_tenths >= vswr_trip);
      rd.temp_high = (rd.heatsink_celsius >= temp_trip);
      return rd;
   endfunction

   function automatic stim_row_type plain(input int f, input int r, input int c, input int h);
      stim_row_type row;
      row.sample  = {f[9:0], r[9:0], c[9:0], h[9:0]};
      row.typed   = 1'b0;
      row.reading = '0;
      return row;
   endfunction

   function automatic stim_row_type known(input int f, input int r, input int c, input int h,
                                          input rsp_payload_type rd);
      stim_row_type row;
      row = plain(f, r, c, h);
      row.typed   = 1'b1;
      row.reading = rd;
      return row;
   endfunction

   // A heatsink reading within a couple of codes of the point where the flag trips.
   function automatic int heat_near_trip();
      int adc;
      adc = (int'(temp_trip) * 65536 + 15996) / 15997 + int'($urandom_range(0, 4)) - 2;
      if (adc < 0) adc = 0;
      if (adc > 1023) adc = 1023;
      return adc;
   endfunction

   // Mostly plausible line readings: reverse below forward, sometimes close to it for a
   // saturated ratio, sometimes above it. One item in ten is unconstrained noise.
   function automatic req_payload_type random_sample(input bit low_run);
      int f;
      int r;
      int c;
      int h;
      if ($urandom_range(0, 9) == 0) begin
         f = $urandom_range(0, 1023);
         r = $urandom_range(0, 1023);
         c = $urandom_range(0, 1023);
         h = $urandom_range(0, 1023);
      end else begin
         f = low_run ? $urandom_range(0, 150) : $urandom_range(0, 1023);
         // Rare spikes in a low run set a peak that must later age out of the window.
         if (low_run && $urandom_range(0, 24) == 0) f = $urandom_range(600, 1023);
         case ($urandom_range(0, 3))
            0: begin
               r = (f > 8) ? f - int'($urandom_range(1, 8)) : 0;
            end
            1: begin
               r = $urandom_range(0, 1023);
            end
            default: begin
               r = $urandom_range(0, f / 2);
            end
         endcase
         c = $urandom_range(0, 1023);
         h = ($urandom_range(0, 2) == 0) ? heat_near_trip() : $urandom_range(0, 1023);
      end
      return {f[9:0], r[9:0], c[9:0], h[9:0]};
   endfunction

   // Offers one item and waits for it to be taken. Valid stays high into the next item
   // unless a gap is drawn.
   task automatic offer(input req_payload_type sample, input bit typed,
                        input rsp_payload_type reading);
      rsp_payload_type predicted;
      req_payload <= sample;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_reading(sample);
      expected_readings.push_back(typed ? reading : predicted);
      items_sent++;
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_VSWR_LIMIT) vswr_trip = value;
      else if (idx == CSR_TEMP_LIMIT) temp_trip = value;
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Each item yields exactly one reading, so an empty store means the block is idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int gap_pct, input int stall_pct);
      bit low_run;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      low_run = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % RUN_LENGTH == 0) low_run = ($urandom_range(0, 2) == 0);
         offer(random_sample(low_run), 1'b0, '0);
      end
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         log_mismatch($sformatf("reading %0d %s got %0d expected %0d",
                                readings_checked, field, got, want));
   endtask

   // Result side: every accepted reading is matched against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            log_mismatch("reading arrived with nothing expected");
         end else begin
            want = expected_readings.pop_front();
            check_field("fwd_watts", rsp_payload.fwd_watts, want.fwd_watts);
            check_field("rev_watts", rsp_payload.rev_watts, want.rev_watts);
            check_field("pa_amps_tenths", rsp_payload.pa_amps_tenths, want.pa_amps_tenths);
            check_field("heatsink_celsius", rsp_payload.heatsink_celsius,
                        want.heatsink_celsius);
            check_field("vswr_tenths", rsp_payload.vswr_tenths, want.vswr_tenths);
            check_field("peak_fwd_watts", rsp_payload.peak_fwd_watts, want.peak_fwd_watts);
            check_field("vswr_high", 8'(rsp_payload.vswr_high), 8'(want.vswr_high));
            check_field("temp_high", 8'(rsp_payload.temp_high), 8'(want.temp_high));
            readings_checked++;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off when the stimulus asks for it.
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (int'($urandom_range(0, 99)) < rsp_stall_pct) begin
            stall_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed table, then random phases under several limit settings.
   initial begin : stimulus
      for (int i = 0; i < WINDOW_DEPTH; i++) fwd_history[i] = 8'd0;
      history_pos = 0;
      vswr_trip   = VSWR_LIMIT_RESET;
      temp_trip   = TEMP_LIMIT_RESET;

      // Typed rows run first under the reset limits: all zero, every field at full
      // scale with matched lines, and full forward against no reverse.
      directed_rows.push_back(known(0, 0, 0, 0,
         {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}));
      directed_rows.push_back(known(1023, 1023, 1023, 1023,
         {8'd241, 8'd241, 8'd249, 8'd249, 8'd0, 8'd241, 1'b0, 1'b1}));
      directed_rows.push_back(known(1023, 0, 1023, 1023,
         {8'd241, 8'd0, 8'd249, 8'd249, 8'd10, 8'd241, 1'b0, 1'b1}));
      // Ratio far beyond the output range, so it saturates.
      directed_rows.push_back(plain(1023, 1022, 0, 0));
      // Reverse above forward gives an invalid ratio of zero.
      directed_rows.push_back(plain(0, 1023, 512, 512));
      directed_rows.push_back(plain(1, 0, 1, 1));
      // Ratio exactly at the reset limit, heat one code below its limit.
      directed_rows.push_back(plain(2, 1, 245, 245));
      // Ratio one below the limit, heat exactly at it.
      directed_rows.push_back(plain(39, 19, 246, 246));
      directed_rows.push_back(plain(10'h2AA, 10'h155, 10'h2AA, 10'h155));
      directed_rows.push_back(plain(10'h155, 10'h2AA, 10'h155, 10'h2AA));
      directed_rows.push_back(plain(512, 511, 100, 300));
      directed_rows.push_back(plain(100, 50, 700, 800));
      directed_rows.push_back(plain(300, 299, 1, 1022));
      directed_rows.push_back(plain(5, 5, 1022, 1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct  = 25;
      rsp_stall_pct = 20;
      foreach (directed_rows[i])
         offer(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].reading);
      wait_idle();

      // Both limits at zero: both flags always set. Spare indexes must be ignored.
      write_csr(CSR_VSWR_LIMIT, 8'd0);
      write_csr(CSR_TEMP_LIMIT, 8'd0);
      write_csr(CSR_SPARE_LO, 8'hFF);
      write_csr(CSR_SPARE_HI, 8'h00);
      // The long receiver hold-off lands early in this phase while items keep coming.
      hold_request = 1'b1;
      run_random(160, 30, 25);
      wait_idle();

      // Both limits at the top: flags only for saturated ratios.
      write_csr(CSR_VSWR_LIMIT, 8'd255);
      write_csr(CSR_TEMP_LIMIT, 8'd255);
      run_random(160, 10, 10);
      wait_idle();

      write_csr(CSR_VSWR_LIMIT, 8'($urandom_range(1, 254)));
      write_csr(CSR_TEMP_LIMIT, 8'($urandom_range(1, 254)));
      run_random(160, 20, 30);
      wait_idle();

      // Closing stretch at full rate on both sides.
      write_csr(CSR_VSWR_LIMIT, 8'd20);
      write_csr(CSR_TEMP_LIMIT, 8'd45);
      run_random(220, 0, 0);
      wait_idle();

      // Any reading beyond the last one would show up here as unexpected.
      repeat (2 * WINDOW_DEPTH + 16) @(posedge clock);

      $display("Run: %0d sample sets, %0d readings checked, %0d register writes.",
               items_sent, readings_checked, csr_writes);
      $display("Covered full-scale and zero inputs, saturated and invalid ratios, limits at"
               , " both ends, spare indexes and a long output stall.");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rpvm_pkg.sv
rtl/rpvm_front.sv
rtl/rpvm_queue.sv
rtl/rpvm_back.sv
rtl/rf_power_vswr_monitor_core.sv
rtl/rpvm_checker.sv
test/tb_rf_power_vswr_monitor_core.sv
